// ----- rtl/oqdf_pkg.sv -----
// package: sizes, op codes and cell control for the ordered queue
package oqdf_pkg;

   // built size of the queue
   localparam int DEPTH = 16;
   localparam int WORD_W = 32;

   // widths of the fixed interface fields
   localparam int OP_W = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W = 4;
   localparam int LIMIT_W = 5;
   localparam int FOUND_W = 5;
   localparam int OCC_W = 5;

   // entry count covers 0..DEPTH, compares run at a width that holds every operand
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // packed stream widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // no match on find, and the value for every other op
   localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_DELETE = 3'd3,
      OP_FIND   = 3'd4,
      OP_CLEAR  = 3'd5
   } op_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;      // take the pushed word
      logic shift;     // take the word of the next cell toward the tail
      logic match_en;  // register the compare against the search key
   } cell_ctrl_type;

endpackage

// ----- rtl/oqdf_cell.sv -----
// one queue cell: holds one word, shifts toward the head and compares against the key
module oqdf_cell (
   input  logic                           clock,
   input  oqdf_pkg::cell_ctrl_type        ctrl,
   input  logic [oqdf_pkg::WORD_W-1:0]    push_word,
   input  logic [oqdf_pkg::WORD_W-1:0]    next_word,
   input  logic [oqdf_pkg::WORD_W-1:0]    key,
   output logic [oqdf_pkg::WORD_W-1:0]    word,
   output logic                           match
);

   logic [oqdf_pkg::WORD_W-1:0] word_ff;
   logic [oqdf_pkg::WORD_W-1:0] word_in;
   logic                        match_ff;
   logic                        match_in;

   // load wins over shift; otherwise hold
   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = push_word;
      end else if (ctrl.shift) begin
         word_in = next_word;
      end
   end

   // compare result registered and held for the encoder until the command executes
   always_comb begin
      match_in = match_ff;
      if (ctrl.match_en) begin
         match_in = (word_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      match_ff <= match_in;
   end

   assign word  = word_ff;
   assign match = match_ff;

endmodule

// ----- rtl/ordered_queue_with_delete_find_top.sv -----
// top level: ordered queue built as a chain of shifting cells with delete and find
//
// The queue takes one operation word at a time. As a word is accepted, every cell
// compares its entry against the search key and registers the result, while the
// word is held in the command register. When the command executes, cells load,
// or shift one place toward the head from the delete position, the first match
// is priority encoded and the result goes into the output register. req_tready
// stays low while a command is held, so a new word is not accepted until the
// last one has executed. The compare is registered in the cells ahead of the
// match encoder. A waiting result does not block the next accept; execution
// waits only while the output register is full and not being taken.
// capacity_limit 0, or above the built depth, means the full depth of 16 entries.
module ordered_queue_with_delete_find_top (
   input  logic                               clock,
   input  logic                               reset,
   // configuration: capacity_limit
   input  logic                               csr_we,
   input  logic [oqdf_pkg::LIMIT_W-1:0]       csr_wdata,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [31:0] value, [35:32] position, [39:36] zero
   input  logic [oqdf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] op
   input  logic [oqdf_pkg::OP_W-1:0]          req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] success, [32:1] read_value, [37:33] found_position, [42:38] occupancy,
   // [47:43] zero
   output logic [oqdf_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int DEPTH = oqdf_pkg::DEPTH;
   localparam int WORD_W = oqdf_pkg::WORD_W;
   localparam int CNT_W = oqdf_pkg::CNT_W;
   localparam int CMP_W = oqdf_pkg::CMP_W;

   // configuration register
   logic [oqdf_pkg::LIMIT_W-1:0] limit_ff;
   logic [oqdf_pkg::LIMIT_W-1:0] limit_in;

   // pending command
   logic                          cmd_valid_ff;
   logic                          cmd_valid_in;
   logic [oqdf_pkg::OP_W-1:0]     cmd_op_ff;
   logic [oqdf_pkg::OP_W-1:0]     cmd_op_in;
   logic [oqdf_pkg::POS_W-1:0]    cmd_pos_ff;
   logic [oqdf_pkg::POS_W-1:0]    cmd_pos_in;
   logic [WORD_W-1:0]             cmd_word_ff;
   logic [WORD_W-1:0]             cmd_word_in;

   // occupancy
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;

   // output register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_ok_ff;
   logic                          rsp_ok_in;
   logic [oqdf_pkg::VALUE_W-1:0]  rsp_read_ff;
   logic [oqdf_pkg::VALUE_W-1:0]  rsp_read_in;
   logic [oqdf_pkg::FOUND_W-1:0]  rsp_found_ff;
   logic [oqdf_pkg::FOUND_W-1:0]  rsp_found_in;
   logic [oqdf_pkg::OCC_W-1:0]    rsp_occ_ff;
   logic [oqdf_pkg::OCC_W-1:0]    rsp_occ_in;

   // cell chain
   oqdf_pkg::cell_ctrl_type       cell_ctrl [DEPTH];
   logic [WORD_W-1:0]             cell_word [DEPTH];
   logic [WORD_W-1:0]             cell_next [DEPTH];
   logic [DEPTH-1:0]              cell_match;
   logic [WORD_W-1:0]             req_word;

   // execute decode
   logic                          req_fire;
   logic                          exec;
   logic [CMP_W-1:0]              count_cmp;
   logic [CMP_W-1:0]              limit_cmp;
   logic [CMP_W-1:0]              allowed;
   logic [CMP_W-1:0]              shift_pos;
   logic                          op_ok;
   logic                          do_push;
   logic                          do_remove;
   logic                          hit_any;
   logic [CMP_W-1:0]              hit_idx;

   assign req_word   = WORD_W'(req_tdata[oqdf_pkg::VALUE_W-1:0]);
   assign req_tready = !cmd_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign exec       = cmd_valid_ff && (!rsp_valid_ff || rsp_tready);

   assign count_cmp = CMP_W'(count_ff);
   assign limit_cmp = CMP_W'(limit_ff);

   // effective capacity
   always_comb begin
      if (limit_cmp == '0 || limit_cmp > CMP_W'(DEPTH)) begin
         allowed = CMP_W'(DEPTH);
      end else begin
         allowed = limit_cmp;
      end
   end

   // first matching live entry, lowest position wins
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_match[i] && (CMP_W'(i) < count_cmp)) begin
            hit_any = 1'b1;
            hit_idx = CMP_W'(i);
         end
      end
   end

   // operation outcome
   always_comb begin
      op_ok     = 1'b0;
      do_push   = 1'b0;
      do_remove = 1'b0;
      shift_pos = '0;
      case (cmd_op_ff)
         oqdf_pkg::OP_PUSH: begin
            op_ok   = (count_cmp < allowed);
            do_push = op_ok;
         end
         oqdf_pkg::OP_POP: begin
            op_ok     = (count_ff != '0);
            do_remove = op_ok;
         end
         oqdf_pkg::OP_PEEK: begin
            op_ok = (count_ff != '0);
         end
         oqdf_pkg::OP_DELETE: begin
            shift_pos = CMP_W'(cmd_pos_ff);
            op_ok     = (shift_pos < count_cmp);
            do_remove = op_ok;
         end
         oqdf_pkg::OP_FIND: begin
            op_ok = hit_any;
         end
         oqdf_pkg::OP_CLEAR: begin
            op_ok = 1'b1;
         end
         default: begin
            op_ok = 1'b0;
         end
      endcase
   end

   // cell chain, each cell fed by its neighbour toward the tail
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_tail
         assign cell_next[g] = '0;
      end else begin : g_mid
         assign cell_next[g] = cell_word[g+1];
      end

      always_comb begin
         cell_ctrl[g].load     = exec && do_push && (CMP_W'(g) == count_cmp);
         cell_ctrl[g].shift    = exec && do_remove && (CMP_W'(g) >= shift_pos);
         cell_ctrl[g].match_en = req_fire;
      end

      oqdf_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .push_word (cmd_word_ff),
         .next_word (cell_next[g]),
         .key       (req_word),
         .word      (cell_word[g]),
         .match     (cell_match[g])
      );
   end

   // next state of command, count and output register
   always_comb begin
      limit_in     = limit_ff;
      cmd_valid_in = cmd_valid_ff;
      cmd_op_in    = cmd_op_ff;
      cmd_pos_in   = cmd_pos_ff;
      cmd_word_in  = cmd_word_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_found_in = rsp_found_ff;
      rsp_occ_in   = rsp_occ_ff;

      if (csr_we) begin
         limit_in = csr_wdata;
      end

      if (req_fire) begin
         cmd_valid_in = 1'b1;
         cmd_op_in    = req_tuser;
         cmd_pos_in   = req_tdata[oqdf_pkg::VALUE_W +: oqdf_pkg::POS_W];
         cmd_word_in  = req_word;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (exec) begin
         cmd_valid_in = 1'b0;
         if (do_push) begin
            count_in = count_ff + CNT_W'(1);
         end else if (do_remove) begin
            count_in = count_ff - CNT_W'(1);
         end else if (cmd_op_ff == oqdf_pkg::OP_CLEAR) begin
            count_in = '0;
         end
         rsp_valid_in = 1'b1;
         rsp_ok_in    = op_ok;
         rsp_read_in  = '0;
         if (op_ok && (cmd_op_ff == oqdf_pkg::OP_POP || cmd_op_ff == oqdf_pkg::OP_PEEK)) begin
            rsp_read_in = oqdf_pkg::VALUE_W'(cell_word[0]);
         end
         rsp_found_in = oqdf_pkg::FOUND_NONE;
         if (cmd_op_ff == oqdf_pkg::OP_FIND && hit_any) begin
            rsp_found_in = oqdf_pkg::FOUND_W'(hit_idx);
         end
         rsp_occ_in = oqdf_pkg::OCC_W'(count_in);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= '0;
         cmd_valid_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         cmd_valid_ff <= cmd_valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_op_ff    <= cmd_op_in;
      cmd_pos_ff   <= cmd_pos_in;
      cmd_word_ff  <= cmd_word_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_read_ff  <= rsp_read_in;
      rsp_found_ff <= rsp_found_in;
      rsp_occ_ff   <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_occ_ff, rsp_found_ff, rsp_read_ff, rsp_ok_ff};

   // occupancy never passes the built depth
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("entry count above depth");

   // a new word is never taken in the cycle a command executes
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && exec))
      else $error("accept overlaps execute");

   // execution always leaves a result in the output register
   assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid_ff)
      else $error("executed command lost its result");

   // a successful push grows the queue by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (exec && do_push) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the queue");

   // a waiting result reports the current occupancy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_occ_ff == oqdf_pkg::OCC_W'(count_ff)))
      else $error("reported occupancy stale");

endmodule
